[src/iirdf1_pkg.sv]
// ----------------------------------------------------------------------------
// iirdf1_pkg: shared types and constants for the direct-form-I IIR filter
// Coefficient ROM (signed Q3.28), datapath widths and the MAC control word.
// ----------------------------------------------------------------------------
package iirdf1_pkg;

   localparam int COEF_W      = 32;
   localparam int DATA_W      = 32;
   localparam int PROD_W      = COEF_W + DATA_W;
   localparam int ACC_W       = 80;
   localparam int OUT_W       = 32;
   localparam int FRAC_SHIFT  = 28;
   localparam int ALIGN_SHIFT = 16;
   localparam int ROM_AW      = 4;

   typedef logic signed [COEF_W-1:0] coef_type;
   typedef logic signed [DATA_W-1:0] data_type;
   typedef logic signed [OUT_W-1:0]  out_type;

   localparam out_type OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
   localparam out_type OUT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

   typedef struct packed {
      logic issue;
      logic align;
      logic negate;
   } mac_ctl_type;

   function automatic coef_type num_coef(input logic [ROM_AW-1:0] idx);
      coef_type c;
      case (idx)
         4'd0:    c = 32'sd515684;
         4'd1:    c = -32'sd4247275;
         4'd2:    c = 32'sd16570974;
         4'd3:    c = -32'sd40038177;
         4'd4:    c = 32'sd66118166;
         4'd5:    c = -32'sd77835927;
         4'd6:    c = 32'sd66118166;
         4'd7:    c = -32'sd40038177;
         4'd8:    c = 32'sd16570974;
         4'd9:    c = -32'sd4247275;
         4'd10:   c = 32'sd515684;
         default: c = '0;
      endcase
      return c;
   endfunction

   function automatic coef_type den_coef(input logic [ROM_AW-1:0] idx);
      coef_type c;
      case (idx)
         4'd0:    c = 32'sd268435456;
         4'd1:    c = -32'sd491984816;
         4'd2:    c = -32'sd328794742;
         4'd3:    c = 32'sd758641667;
         4'd4:    c = 32'sd438243630;
         4'd5:    c = -32'sd667453458;
         4'd6:    c = -32'sd331163932;
         4'd7:    c = 32'sd284034643;
         4'd8:    c = 32'sd146767433;
         4'd9:    c = -32'sd49644867;
         4'd10:   c = -32'sd27078198;
         default: c = '0;
      endcase
      return c;
   endfunction

endpackage

[src/iirdf1_mac.sv]
// ----------------------------------------------------------------------------
// iirdf1_mac: shared multiply-accumulate unit
// Registered 32x32 product, wide accumulator, round to nearest and saturate.
// ----------------------------------------------------------------------------
module iirdf1_mac (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    clear,
   input  iirdf1_pkg::mac_ctl_type ctl,
   input  iirdf1_pkg::coef_type    coef,
   input  iirdf1_pkg::data_type    data,
   output iirdf1_pkg::out_type     result
);

   localparam logic signed [iirdf1_pkg::ACC_W-1:0] HALF_LSB =
      iirdf1_pkg::ACC_W'(1) << (iirdf1_pkg::FRAC_SHIFT - 1);

   logic signed [iirdf1_pkg::PROD_W-1:0] prod_ff;
   logic signed [iirdf1_pkg::PROD_W-1:0] prod_in;
   iirdf1_pkg::mac_ctl_type              ctl_ff;
   logic signed [iirdf1_pkg::ACC_W-1:0]  acc_ff;
   logic signed [iirdf1_pkg::ACC_W-1:0]  acc_in;
   logic signed [iirdf1_pkg::ACC_W-1:0]  term;
   logic signed [iirdf1_pkg::ACC_W-1:0]  rnd;
   logic signed [iirdf1_pkg::ACC_W-1:0]  quo;
   logic [iirdf1_pkg::ACC_W-iirdf1_pkg::OUT_W:0] upper;
   logic                                 fits;

   assign prod_in = coef * data;

   always_comb begin
      term = iirdf1_pkg::ACC_W'(prod_ff);
      if (ctl_ff.align) begin
         term = term <<< iirdf1_pkg::ALIGN_SHIFT;
      end
      acc_in = acc_ff;
      if (clear) begin
         acc_in = '0;
      end else if (ctl_ff.issue) begin
         acc_in = ctl_ff.negate ? (acc_ff - term) : (acc_ff + term);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else begin
         ctl_ff <= ctl;
      end
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
   end

   // round half up, then clamp to the 32-bit range
   always_comb begin
      rnd   = acc_ff + HALF_LSB;
      quo   = rnd >>> iirdf1_pkg::FRAC_SHIFT;
      upper = quo[iirdf1_pkg::ACC_W-1:iirdf1_pkg::OUT_W-1];
      fits  = (&upper) | ~(|upper);
      if (fits) begin
         result = quo[iirdf1_pkg::OUT_W-1:0];
      end else if (quo[iirdf1_pkg::ACC_W-1]) begin
         result = iirdf1_pkg::OUT_MIN;
      end else begin
         result = iirdf1_pkg::OUT_MAX;
      end
   end

endmodule

[src/iir_direct_form1_order10.sv]
// Each accepted sample runs 2*TAPS-1 products (21 for the default 11 taps) through one
// shared 32x32 multiplier at one product per cycle; a drain step then empties the product
// register and a finish step rounds, saturates and loads the output register, after which
// the block returns to idle, where req_stall is low and the next sample can be accepted.
// req_stall is high while a sample is in progress; a finished result waits in the output
// register and the next sample is taken while it does. The round step holds while an
// earlier result is still stalled.
// ----------------------------------------------------------------------------
// iir_direct_form1_order10: direct-form-I IIR filter, sequential shared MAC
// Keeps input and output histories in shift registers and walks the taps.
// ----------------------------------------------------------------------------
module iir_direct_form1_order10 #(
   parameter int TAPS         = 11,
   parameter int SAMPLE_WIDTH = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic signed [SAMPLE_WIDTH-1:0] req_sample,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic signed [31:0]            rsp_filtered
);

   localparam int DEPTH = TAPS - 1;
   localparam int TAP_W = $clog2(TAPS);
   localparam logic [TAP_W-1:0] LAST_TAP = TAP_W'(TAPS - 1);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_MUL    = 2'd1;
   localparam logic [1:0] ST_DRAIN  = 2'd2;
   localparam logic [1:0] ST_FINISH = 2'd3;

   logic [1:0]                     state_ff;
   logic [TAP_W-1:0]               tap_ff;
   logic                           phase_ff;
   logic signed [SAMPLE_WIDTH-1:0] x_ff;
   logic signed [SAMPLE_WIDTH-1:0] xh_ff [DEPTH];
   iirdf1_pkg::out_type            yh_ff [DEPTH];
   logic                           rsp_valid_ff;
   iirdf1_pkg::out_type            rsp_filtered_ff;

   logic                           req_accept;
   logic                           finish_go;
   logic                           rotate;
   logic signed [SAMPLE_WIDTH-1:0] x_sel;
   logic [iirdf1_pkg::ROM_AW-1:0]  coef_idx;
   iirdf1_pkg::mac_ctl_type        mac_ctl;
   iirdf1_pkg::coef_type           mac_coef;
   iirdf1_pkg::data_type           mac_data;
   iirdf1_pkg::out_type            mac_result;

   assign req_stall    = (state_ff != ST_IDLE);
   assign req_accept   = req_valid & ~req_stall;
   assign finish_go    = (state_ff == ST_FINISH) & (~rsp_valid_ff | ~rsp_stall);
   assign rotate       = (state_ff == ST_MUL) & phase_ff;
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_filtered = rsp_filtered_ff;

   always_comb begin
      coef_idx       = iirdf1_pkg::ROM_AW'(tap_ff);
      mac_ctl.issue  = (state_ff == ST_MUL);
      mac_ctl.align  = ~phase_ff;
      mac_ctl.negate = phase_ff;
      mac_coef = phase_ff ? iirdf1_pkg::den_coef(coef_idx) : iirdf1_pkg::num_coef(coef_idx);
      x_sel    = (tap_ff == '0) ? x_ff : xh_ff[0];
      if (phase_ff) begin
         mac_data = yh_ff[0];
      end else begin
         mac_data = {{(iirdf1_pkg::DATA_W-SAMPLE_WIDTH){x_sel[SAMPLE_WIDTH-1]}}, x_sel};
      end
   end

   iirdf1_mac u_mac (
      .clock  (clock),
      .reset  (reset),
      .clear  (req_accept),
      .ctl    (mac_ctl),
      .coef   (mac_coef),
      .data   (mac_data),
      .result (mac_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         tap_ff   <= '0;
         phase_ff <= 1'b0;
      end else begin
         case (state_ff)
            ST_IDLE: begin
               if (req_accept) begin
                  state_ff <= ST_MUL;
                  tap_ff   <= '0;
                  phase_ff <= 1'b0;
               end
            end
            ST_MUL: begin
               if (tap_ff == '0) begin
                  tap_ff <= tap_ff + TAP_W'(1);
               end else if (!phase_ff) begin
                  phase_ff <= 1'b1;
               end else begin
                  phase_ff <= 1'b0;
                  if (tap_ff == LAST_TAP) begin
                     state_ff <= ST_DRAIN;
                  end else begin
                     tap_ff <= tap_ff + TAP_W'(1);
                  end
               end
            end
            ST_DRAIN: begin
               state_ff <= ST_FINISH;
            end
            ST_FINISH: begin
               if (finish_go) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         x_ff <= req_sample;
      end
   end

   // rotate the histories once per tap after tap 0, shift in the new pair at the end
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < DEPTH; i++) begin
            xh_ff[i] <= '0;
            yh_ff[i] <= '0;
         end
      end else if (rotate) begin
         for (int i = 0; i < DEPTH - 1; i++) begin
            xh_ff[i] <= xh_ff[i+1];
            yh_ff[i] <= yh_ff[i+1];
         end
         xh_ff[DEPTH-1] <= xh_ff[0];
         yh_ff[DEPTH-1] <= yh_ff[0];
      end else if (finish_go) begin
         for (int i = DEPTH - 1; i > 0; i--) begin
            xh_ff[i] <= xh_ff[i-1];
            yh_ff[i] <= yh_ff[i-1];
         end
         xh_ff[0] <= x_ff;
         yh_ff[0] <= mac_result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (finish_go) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
      if (finish_go) begin
         rsp_filtered_ff <= mac_result;
      end
   end

`ifndef SYNTH
   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> (state_ff == ST_MUL) && (tap_ff == '0) && !phase_ff)
      else $error("accepted transaction did not start the tap walk");

   a_result_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_FINISH)
      else $error("result appeared outside the finish step");

   a_tap_range: assert property (@(posedge clock) disable iff (reset)
      tap_ff <= LAST_TAP)
      else $error("tap counter past the last tap");

   a_hold_on_stall: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FINISH) && rsp_valid_ff && rsp_stall |=> state_ff == ST_FINISH)
      else $error("finish step overwrote a pending result");
`endif

endmodule

[tb/sv/filter_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// filter_checker: output predictor and comparator for the order-10 IIR filter
// Watches both channels, runs a bit-exact fixed-point model of the filter on
// every accepted sample and compares each accepted output in order.
// ----------------------------------------------------------------------------
module filter_checker (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_stall,
   input  logic signed [15:0]   req_sample,
   input  logic                 rsp_valid,
   input  logic                 rsp_stall,
   input  iirdf1_pkg::out_type  rsp_filtered,
   output int                   fail_count,
   output int                   pending
);

   localparam int TAP_CNT = 11;
   localparam int REPORT_MAX = 10;

   localparam logic signed [31:0] NUM_Q28 [0:TAP_CNT-1] = '{
      32'sd515684, -32'sd4247275, 32'sd16570974, -32'sd40038177, 32'sd66118166,
      -32'sd77835927, 32'sd66118166, -32'sd40038177, 32'sd16570974, -32'sd4247275,
      32'sd515684
   };
   localparam logic signed [31:0] DEN_Q28 [0:TAP_CNT-1] = '{
      32'sd268435456, -32'sd491984816, -32'sd328794742, 32'sd758641667,
      32'sd438243630, -32'sd667453458, -32'sd331163932, 32'sd284034643,
      32'sd146767433, -32'sd49644867, -32'sd27078198
   };

   localparam logic signed [127:0] SAT_HI = 128'sh7FFF_FFFF;
   localparam logic signed [127:0] SAT_LO = -128'sh8000_0000;

   logic signed [15:0]   sample_hist [0:TAP_CNT-2];
   iirdf1_pkg::out_type  filtered_hist [0:TAP_CNT-2];
   iirdf1_pkg::out_type  filtered_due [$];

   function automatic iirdf1_pkg::out_type next_filtered(input logic signed [15:0] x);
      logic signed [63:0]  prod;
      logic signed [127:0] term;
      logic signed [127:0] acc;
      iirdf1_pkg::out_type y;
      prod = NUM_Q28[0] * x;
      term = prod;
      acc = term <<< 16;
      for (int k = 1; k < TAP_CNT; k++) begin
         prod = NUM_Q28[k] * sample_hist[k-1];
         term = prod;
         acc = acc + (term <<< 16);
         prod = DEN_Q28[k] * filtered_hist[k-1];
         term = prod;
         acc = acc - term;
      end
      acc = acc + (128'sd1 <<< 27);
      acc = acc >>> 28;
      if (acc > SAT_HI) y = iirdf1_pkg::OUT_MAX;
      else if (acc < SAT_LO) y = iirdf1_pkg::OUT_MIN;
      else y = acc[31:0];
      for (int k = TAP_CNT - 2; k > 0; k--) begin
         sample_hist[k] = sample_hist[k-1];
         filtered_hist[k] = filtered_hist[k-1];
      end
      sample_hist[0] = x;
      filtered_hist[0] = y;
      return y;
   endfunction

   always @(posedge clock) begin
      iirdf1_pkg::out_type want;
      if (reset) begin
         for (int k = 0; k < TAP_CNT - 1; k++) begin
            sample_hist[k] = '0;
            filtered_hist[k] = '0;
         end
         filtered_due.delete();
         fail_count = 0;
      end else begin
         if (req_valid && !req_stall)
            filtered_due.push_back(next_filtered(req_sample));
         if (rsp_valid && !rsp_stall) begin
            if (filtered_due.size() == 0) begin
               if (fail_count < REPORT_MAX)
                  $display("%0t: unexpected output filtered=%0d", $realtime, rsp_filtered);
               fail_count++;
            end else begin
               want = filtered_due.pop_front();
               if (rsp_filtered !== want) begin
                  if (fail_count < REPORT_MAX)
                     $display("%0t: filtered mismatch, expected %0d (0x%08h) got %0d (0x%08h)",
                              $realtime, want, want, rsp_filtered, rsp_filtered);
                  fail_count++;
               end
            end
         end
      end
      pending = filtered_due.size();
   end

endmodule

[tb/sv/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: stimulus and verdict for the order-10 direct-form-I IIR filter
// Drives directed extremes, then bursts of full-scale square waves, noise, steps,
// zero runs, small values and random extremes with random idling on both channels.
// ----------------------------------------------------------------------------
module tb_top;

   localparam int ITEM_TARGET  = 1450;
   localparam int QUIET_LIMIT  = 4000;
   localparam int DRAIN_CYCLES = 40;
   localparam int DIRECTED_CNT = 24;

   localparam logic signed [15:0] DIRECTED [0:DIRECTED_CNT-1] = '{
      16'sd0, 16'sd32767, 16'sd0, 16'sd0, 16'sh8000, 16'sd0, 16'sd1, -16'sd1,
      16'sd32767, 16'sh8000, 16'sd32767, 16'sh8000, 16'sd32767, 16'sd32767,
      16'sd32767, 16'sd32767, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000,
      16'sh5555, 16'shAAAA, 16'sd0, 16'sd0
   };

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic signed [15:0]  req_sample = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   iirdf1_pkg::out_type rsp_filtered;

   int fail_count;
   int pending;
   int send_idle_max = 13;
   int recv_idle_max = 13;
   int items_sent = 0;
   int quiet_cycles = 0;

   always #5 clock = ~clock;

   iir_direct_form1_order10 DUT (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_sample   (req_sample),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_filtered (rsp_filtered)
   );

   filter_checker u_checker (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_sample   (req_sample),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_filtered (rsp_filtered),
      .fail_count   (fail_count),
      .pending      (pending)
   );

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   initial begin : output_side
      int hold;
      wait (!reset);
      @(negedge clock);
      forever begin
         hold = $urandom_range(recv_idle_max, 0);
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(negedge clock);
            rsp_stall <= 1'b0;
         end
         do @(posedge clock); while (!(rsp_valid && !rsp_stall));
         @(negedge clock);
      end
   end

   task automatic send_sample(input logic signed [15:0] s);
      int gap;
      gap = $urandom_range(send_idle_max, 0);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_sample <= s;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
      items_sent++;
   endtask

   // hold off until every outstanding output has been taken
   task automatic drain_outputs();
      req_valid <= 1'b0;
      do @(negedge clock); while (pending != 0);
   endtask

   initial begin : stimulus
      int kind;
      int len;
      int half;
      logic signed [15:0] s;
      logic signed [15:0] level;
      repeat (4) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      for (int i = 0; i < DIRECTED_CNT; i++)
         send_sample(DIRECTED[i]);
      drain_outputs();
      while (items_sent < ITEM_TARGET) begin
         send_idle_max = ($urandom_range(3, 0) == 0) ? 0 : 13;
         recv_idle_max = ($urandom_range(3, 0) == 0) ? 0 : 13;
         kind = $urandom_range(9, 0);
         len = $urandom_range(60, 10);
         half = $urandom_range(12, 1);
         level = 16'($urandom());
         for (int i = 0; i < len; i++) begin
            case (kind)
               0, 1, 2, 3: s = ((i / half) % 2 == 0) ? 16'sd32767 : 16'sh8000;
               4, 5:       s = 16'($urandom());
               6: begin
                  case ($urandom_range(4, 0))
                     0:       s = 16'sd32767;
                     1:       s = 16'sh8000;
                     2:       s = 16'sd0;
                     3:       s = -16'sd1;
                     default: s = 16'sd1;
                  endcase
               end
               7:          s = 16'(int'($urandom_range(8, 0)) - 4);
               8:          s = 16'sd0;
               default:    s = level;
            endcase
            send_sample(s);
         end
         if ($urandom_range(19, 0) == 0)
            drain_outputs();
      end
      req_valid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (fail_count == 0 && pending == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule

[files.f]
src/iirdf1_pkg.sv
src/iirdf1_mac.sv
src/iir_direct_form1_order10.sv
tb/sv/filter_checker.sv
tb/sv/tb_top.sv
